@@ rtl/voice_stream_jitter_bandwidth_monitor_macros.svh @@
// assertion macros for the voice stream jitter and bandwidth monitor
// used by the datapath; expects signals clk and rst in scope
`ifndef VOICE_STREAM_JITTER_BANDWIDTH_MONITOR_MACROS_SVH
`define VOICE_STREAM_JITTER_BANDWIDTH_MONITOR_MACROS_SVH

// condition implies consequence in the same cycle
`define VSJM_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define VSJM_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

@@ rtl/vsjm_pkg.sv @@
// shared types and constants of the voice stream jitter and bandwidth monitor
// no dependencies
`default_nettype none
package vsjm_pkg;

  localparam int RING_DEPTH_DEF   = 256;
  localparam int JITTER_SHIFT_DEF = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] WINDOW_US_RST    = 24'd1000000;
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd24;
  localparam logic [9:0]  TS_SCALE         = 10'd1000;
  localparam logic [47:0] DIFF_MAX         = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] GAP_MAX          = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] GAP_MIN          = 48'h8000_0000_0000;
  localparam logic [26:0] BITS_MAX         = 27'h7FF_FFFF;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_US    = 1'b0,
    REG_HEADER_BYTES = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [47:0] arrival_us;
    logic [31:0] media_ts_ms;
    logic [15:0] payload_bytes;
    logic        is_voice;
    logic [31:0] codec_sub;
    logic [31:0] packet_num;
  } in_item_t;

  typedef struct packed {
    logic        first_seen;
    logic        codec_changed;
    logic        regular_codec_changed;
    logic [47:0] gap_us;
    logic [47:0] diff_us;
    logic [51:0] jitter_q4;
    logic [47:0] max_gap_us;
    logic [31:0] max_gap_packet;
    logic [51:0] max_jitter_q4;
    logic [51:0] mean_diff_q4;
    logic [26:0] window_bits;
    logic        window_full;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic calc_a;
    logic calc_b;
    logic calc_c;
    logic full_drop;
    logic wr;
    logic ev_drop;
    logic div_start;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ring_full;
    logic ev_hit;
    logic first;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/vsjm_div.sv @@
// restoring divider, one quotient bit per cycle
// uses no package items
`default_nettype none
module vsjm_div #(
  parameter int DVD_W = 52,
  parameter int DVS_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             fits;

  // trial subtraction of the shifted remainder
  always_comb begin
    trial = {rem, q[DVD_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // iteration counter and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      q   <= dividend;
    end else if (busy) begin
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      q   <= {q[DVD_W-2:0], fits};
    end
  end

  assign quotient = q;

endmodule
`default_nettype wire

@@ rtl/vsjm_dp.sv @@
// datapath: transit difference, jitter, peaks, mean and the bandwidth ring
// depends on vsjm_pkg, vsjm_div and the assertion macro header
`default_nettype none
`include "voice_stream_jitter_bandwidth_monitor_macros.svh"
module vsjm_dp #(
  parameter int RING_DEPTH   = vsjm_pkg::RING_DEPTH_DEF,
  parameter int JITTER_SHIFT = vsjm_pkg::JITTER_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vsjm_pkg::cmd_t                      cmd,
  output vsjm_pkg::status_t                   sts,
  input  vsjm_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  input  logic [vsjm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vsjm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vsjm_pkg::out_item_t                 out_data
);
  import vsjm_pkg::*;

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int USED_W = $clog2(RING_DEPTH + 1);
  localparam int WB_W   = 17 + USED_W;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [USED_W-1:0] DEPTH_U  = USED_W'(RING_DEPTH);

  typedef struct packed {
    logic [47:0] t;
    logic [16:0] b;
  } entry_t;

  // configuration
  logic [23:0] window_us;
  logic [7:0]  header_bytes;

  // model state
  logic [47:0] last_arrival;
  logic [31:0] last_media_ts;
  logic [31:0] stored_codec;
  logic [31:0] regular_codec;
  logic        regular_codec_valid;
  logic        awaiting_first;
  logic [51:0] jitter_acc;
  logic [47:0] peak_gap;
  logic [31:0] peak_gap_packet;
  logic [51:0] peak_jitter;
  logic [51:0] mean_acc;
  logic [31:0] packet_count;
  logic [IDX_W-1:0]  ring_head;
  logic [IDX_W-1:0]  ring_tail;
  logic [USED_W-1:0] ring_used;
  logic [WB_W-1:0]   window_bytes;
  entry_t ring_mem [RING_DEPTH];
  entry_t ring_rd;

  // per item work registers
  in_item_t    item;
  logic        codec_chg;
  logic        window_full;
  logic [48:0] darr;
  logic [42:0] dts_k;
  logic [47:0] diff;
  logic [47:0] gap;
  logic [51:0] jit;
  logic [51:0] mean_err;
  logic        mean_up;

  // combinational helpers
  logic [32:0] dts;
  logic [51:0] transit;
  logic [51:0] transit_abs;
  logic [51:0] diff16;
  logic [51:0] jit_up;
  logic [51:0] jit_dn;
  logic [51:0] mean_up_e;
  logic [51:0] mean_dn_e;
  logic [51:0] quotient;
  logic [32:0] divisor;
  logic        div_done;
  logic [51:0] mean_next;
  logic [47:0] peak_gap_next;
  logic [31:0] peak_pkt_next;
  logic [51:0] peak_jit_next;
  logic        reg_chg;
  logic [16:0] entry_bytes;
  logic [48:0] ev_limit;
  logic [WB_W+2:0] wbits;
  logic [26:0] window_bits;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_us    <= WINDOW_US_RST;
      header_bytes <= HEADER_BYTES_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_US:    window_us    <= cfg_data;
        REG_HEADER_BYTES: header_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // transit arithmetic
  always_comb begin
    dts         = {1'b0, item.media_ts_ms} - {1'b0, last_media_ts};
    transit     = {{3{darr[48]}}, darr} - {{9{dts_k[42]}}, dts_k};
    transit_abs = transit[51] ? (52'd0 - transit) : transit;
    diff16      = {diff, 4'b0};
    jit_up      = diff16 - jitter_acc;
    jit_dn      = jitter_acc - diff16;
    mean_up_e   = diff16 - mean_acc;
    mean_dn_e   = mean_acc - diff16;
    divisor     = {1'b0, packet_count} + 33'd1;
  end

  // per item stages
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
    if (cmd.calc_a) begin
      darr        <= {1'b0, item.arrival_us} - {1'b0, last_arrival};
      dts_k       <= {{10{dts[32]}}, dts} * {33'd0, TS_SCALE};
      codec_chg   <= item.is_voice && (item.codec_sub != stored_codec);
      window_full <= 1'b0;
    end
    if (cmd.calc_b) begin
      diff <= (|transit_abs[51:48]) ? DIFF_MAX : transit_abs[47:0];
      if (darr[48] != darr[47]) begin
        gap <= darr[48] ? GAP_MIN : GAP_MAX;
      end else begin
        gap <= darr[47:0];
      end
    end
    if (cmd.calc_c) begin
      if (diff16 >= jitter_acc) begin
        jit <= jitter_acc + (jit_up >> JITTER_SHIFT);
      end else begin
        jit <= jitter_acc - (jit_dn >> JITTER_SHIFT);
      end
      mean_up  <= diff16 >= mean_acc;
      mean_err <= (diff16 >= mean_acc) ? mean_up_e : mean_dn_e;
    end
    if (cmd.full_drop) begin
      window_full <= 1'b1;
    end
  end

  // mean step divider
  vsjm_div #(
    .DVD_W(52),
    .DVS_W(33)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mean_err),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // next values of the tracked statistics
  always_comb begin
    mean_next     = mean_up ? (mean_acc + quotient) : (mean_acc - quotient);
    peak_gap_next = peak_gap;
    peak_pkt_next = peak_gap_packet;
    peak_jit_next = peak_jitter;
    reg_chg       = 1'b0;
    if (!awaiting_first) begin
      if ($signed(gap) > $signed(peak_gap)) begin
        peak_gap_next = gap;
        peak_pkt_next = item.packet_num;
      end
      if (jit > peak_jitter) begin
        peak_jit_next = jit;
      end
      reg_chg = (stored_codec != regular_codec) && regular_codec_valid;
    end
  end

  // commit of the stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_arrival        <= '0;
      last_media_ts       <= '0;
      stored_codec        <= '0;
      regular_codec       <= '0;
      regular_codec_valid <= 1'b0;
      awaiting_first      <= 1'b1;
      jitter_acc          <= '0;
      peak_gap            <= '0;
      peak_gap_packet     <= '0;
      peak_jitter         <= '0;
      mean_acc            <= '0;
      packet_count        <= '0;
    end else begin
      if (cmd.calc_a && item.is_voice) begin
        stored_codec <= item.codec_sub;
      end
      if (cmd.commit) begin
        jitter_acc          <= awaiting_first ? 52'd0 : jit;
        peak_gap            <= peak_gap_next;
        peak_gap_packet     <= peak_pkt_next;
        peak_jitter         <= peak_jit_next;
        if (!awaiting_first) begin
          mean_acc <= mean_next;
        end
        regular_codec       <= stored_codec;
        regular_codec_valid <= 1'b1;
        last_arrival        <= item.arrival_us;
        last_media_ts       <= item.media_ts_ms;
        awaiting_first      <= 1'b0;
        if (packet_count != COUNT_MAX) begin
          packet_count <= packet_count + 32'd1;
        end
      end
    end
  end

  // ring memory, tail read registered every cycle
  assign entry_bytes = {1'b0, item.payload_bytes} + {9'd0, header_bytes};

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ring_mem[ring_head] <= '{t: item.arrival_us, b: entry_bytes};
    end
    ring_rd <= ring_mem[ring_tail];
  end

  // ring pointers and byte sum
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head    <= '0;
      ring_tail    <= '0;
      ring_used    <= '0;
      window_bytes <= '0;
    end else if (cmd.wr) begin
      ring_head    <= (ring_head == LAST_IDX) ? '0 : ring_head + 1'b1;
      ring_used    <= ring_used + 1'b1;
      window_bytes <= window_bytes + WB_W'(entry_bytes);
    end else if (cmd.full_drop || cmd.ev_drop) begin
      ring_tail    <= (ring_tail == LAST_IDX) ? '0 : ring_tail + 1'b1;
      ring_used    <= ring_used - 1'b1;
      window_bytes <= window_bytes - WB_W'(ring_rd.b);
    end
  end

  // status to the controller
  assign ev_limit      = {1'b0, ring_rd.t} + {25'd0, window_us};
  assign sts.ring_full = ring_used >= DEPTH_U;
  assign sts.ev_hit    = (ring_used > USED_W'(1)) && (ev_limit < {1'b0, item.arrival_us});
  assign sts.first     = awaiting_first;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || !out_stall;

  // window bits with saturation
  assign wbits       = {window_bytes, 3'b000};
  assign window_bits = (wbits > (WB_W + 3)'(BITS_MAX)) ? BITS_MAX : wbits[26:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.first_seen            <= awaiting_first;
      out_data.codec_changed         <= codec_chg;
      out_data.regular_codec_changed <= reg_chg;
      out_data.gap_us                <= awaiting_first ? 48'd0 : gap;
      out_data.diff_us               <= awaiting_first ? 48'd0 : diff;
      out_data.jitter_q4             <= awaiting_first ? 52'd0 : jit;
      out_data.max_gap_us            <= peak_gap_next;
      out_data.max_gap_packet        <= peak_pkt_next;
      out_data.max_jitter_q4         <= peak_jit_next;
      out_data.mean_diff_q4          <= awaiting_first ? mean_acc : mean_next;
      out_data.window_bits           <= window_bits;
      out_data.window_full           <= window_full;
    end
  end

  // checks on ring bookkeeping and the result handoff
  `VSJM_ASSERT_NOW(a_used_bound, 1'b1, ring_used <= DEPTH_U, "ring count above depth")
  `VSJM_ASSERT_NOW(a_full_drop, cmd.full_drop, ring_used == DEPTH_U, "drop of a ring not full")
  `VSJM_ASSERT_NOW(a_ev_keep, cmd.ev_drop, ring_used > USED_W'(1), "eviction of newest entry")
  `VSJM_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || !out_stall, "result overwritten")

endmodule
`default_nettype wire

@@ rtl/vsjm_ctrl.sv @@
// controller state machine sequencing one packet through the datapath
// depends on vsjm_pkg
`default_nettype none
module vsjm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vsjm_pkg::status_t sts,
  output vsjm_pkg::cmd_t    cmd
);
  import vsjm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_CALC_A    = 12'b0000_0000_0010,
    S_CALC_B    = 12'b0000_0000_0100,
    S_CALC_C    = 12'b0000_0000_1000,
    S_FULL_RD   = 12'b0000_0001_0000,
    S_FULL_DROP = 12'b0000_0010_0000,
    S_WRITE     = 12'b0000_0100_0000,
    S_EV_RD     = 12'b0000_1000_0000,
    S_EV_CHK    = 12'b0001_0000_0000,
    S_DIV_GO    = 12'b0010_0000_0000,
    S_DIV_WAIT  = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_CALC_A;
      end
      S_CALC_A: begin
        cmd.calc_a = 1'b1;
        state_next = S_CALC_B;
      end
      S_CALC_B: begin
        cmd.calc_b = 1'b1;
        state_next = S_CALC_C;
      end
      S_CALC_C: begin
        cmd.calc_c = 1'b1;
        state_next = sts.ring_full ? S_FULL_RD : S_WRITE;
      end
      S_FULL_RD: begin
        state_next = S_FULL_DROP;
      end
      S_FULL_DROP: begin
        cmd.full_drop = 1'b1;
        state_next    = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = S_EV_RD;
      end
      S_EV_RD: begin
        state_next = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (sts.ev_hit) begin
          cmd.ev_drop = 1'b1;
          state_next  = S_EV_RD;
        end else begin
          state_next = sts.first ? S_DONE : S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // no request is taken during reset
  assign in_stall = rst || (state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/voice_stream_jitter_bandwidth_monitor.sv @@
// top level of the voice stream jitter and bandwidth monitor
// depends on vsjm_pkg, vsjm_ctrl and vsjm_dp
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | request   | in_valid/in_stall  | in_data (in_item_t)
//   out     | result    | out_valid/out_stall| out_data (out_item_t)
//   cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a packet holds the input from acceptance to commit: three calc steps, a read and a
// forced drop when the ring is full, the ring write, a read and check per eviction walk step,
// the one-bit-per-cycle mean divider (not on the first packet), then the commit
// reset is synchronous, stalls the input and leaves the ring empty; no clearing pass
// a waiting result sits in the output register while the next request is taken
// configuration writes are taken in every cycle outside reset
`default_nettype none
module voice_stream_jitter_bandwidth_monitor #(
  parameter int RING_DEPTH   = vsjm_pkg::RING_DEPTH_DEF,
  parameter int JITTER_SHIFT = vsjm_pkg::JITTER_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vsjm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vsjm_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vsjm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsjm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vsjm_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = !rst;

  vsjm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsjm_dp #(
    .RING_DEPTH   (RING_DEPTH),
    .JITTER_SHIFT (JITTER_SHIFT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ tb/voice_stream_jitter_bandwidth_monitor_tb.sv @@
// testbench for the voice stream jitter and bandwidth monitor
// drives packets and register writes, predicts each per-packet result and compares
// depends on vsjm_pkg and the rtl top voice_stream_jitter_bandwidth_monitor
`timescale 1ns / 1ps
`default_nettype none

module voice_stream_jitter_bandwidth_monitor_tb;
  import vsjm_pkg::*;

  localparam longint S48_MAX  = 64'sd140737488355327;
  localparam longint S48_MIN  = -64'sd140737488355328;
  localparam longint unsigned M48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned BITS_CAP = 64'd134217727;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 700;
  localparam int HOLD_CYCLES = 3000;

  // stream statistics predictor and result checker
  class vsjm_scoreboard;
    longint unsigned window_us, header_bytes;
    longint unsigned last_arrival, jitter_acc, peak_jitter, mean_acc, window_bytes;
    longint unsigned last_media_ts, stored_codec, regular_codec, peak_gap_packet;
    longint unsigned packet_count;
    longint peak_gap;
    bit regular_codec_valid, awaiting_first;
    longint unsigned ring_time[RING_DEPTH_DEF];
    longint unsigned ring_bytes[RING_DEPTH_DEF];
    int head, tail, used;
    out_item_t expected_stats[$];
    int errors, n_requests, n_results, n_full, n_evict_runs;

    function void clear();
      window_us = WINDOW_US_RST;
      header_bytes = HEADER_BYTES_RST;
      last_arrival = 0; last_media_ts = 0; stored_codec = 0; regular_codec = 0;
      regular_codec_valid = 0; awaiting_first = 1;
      jitter_acc = 0; peak_gap = 0; peak_gap_packet = 0; peak_jitter = 0;
      mean_acc = 0; packet_count = 0; window_bytes = 0;
      head = 0; tail = 0; used = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WINDOW_US) window_us = val;
      else header_bytes = val[7:0];
    endfunction

    function longint unsigned step_toward(longint unsigned acc, longint unsigned tgt,
                                          longint unsigned div, bit use_shift);
      longint unsigned e;
      if (tgt >= acc) begin
        e = tgt - acc;
        return acc + (use_shift ? (e >> JITTER_SHIFT_DEF) : e / div);
      end
      e = acc - tgt;
      return acc - (use_shift ? (e >> JITTER_SHIFT_DEF) : e / div);
    endfunction

    function void drop_oldest();
      window_bytes -= ring_bytes[tail];
      tail = (tail + 1) % RING_DEPTH_DEF;
      used--;
    endfunction

    // work out the result of one accepted request
    function void note_packet(in_item_t p);
      longint darr, dts, transit, gap, ts_now, ts_prev;
      longint unsigned arr, diff, jit, bits;
      bit first, full, cc, rc;
      out_item_t e;
      int drops;
      first = 0; full = 0; cc = 0; rc = 0; drops = 0;
      arr = p.arrival_us;
      n_requests++;
      if (p.is_voice) begin
        cc = (p.codec_sub != stored_codec);
        stored_codec = p.codec_sub;
      end
      ts_now = p.media_ts_ms;
      ts_prev = last_media_ts;
      darr = longint'(arr) - longint'(last_arrival);
      dts = ts_now - ts_prev;
      transit = darr - dts * 1000;
      diff = transit < 0 ? -transit : transit;
      if (diff > M48) diff = M48;
      jit = step_toward(jitter_acc, diff << 4, 1, 1);
      gap = darr > S48_MAX ? S48_MAX : (darr < S48_MIN ? S48_MIN : darr);
      // bandwidth ring: forced drop when full, then time-based eviction
      if (used >= RING_DEPTH_DEF) begin
        drop_oldest();
        full = 1;
      end
      ring_time[head] = arr;
      ring_bytes[head] = p.payload_bytes + header_bytes;
      window_bytes += p.payload_bytes + header_bytes;
      head = (head + 1) % RING_DEPTH_DEF;
      used++;
      while (used > 1 && ring_time[tail] + window_us < arr) begin
        drop_oldest();
        drops++;
      end
      if (drops > 1) n_evict_runs++;
      if (awaiting_first) begin
        gap = 0; diff = 0; jit = 0; first = 1; awaiting_first = 0;
      end
      jitter_acc = jit;
      if (!first) begin
        if (gap > peak_gap) begin
          peak_gap = gap;
          peak_gap_packet = p.packet_num;
        end
        if (jit > peak_jitter) peak_jitter = jit;
        mean_acc = step_toward(mean_acc, diff << 4, packet_count + 1, 0);
        rc = (stored_codec != regular_codec) && regular_codec_valid;
      end
      regular_codec = stored_codec;
      regular_codec_valid = 1;
      last_arrival = arr;
      last_media_ts = p.media_ts_ms;
      if (packet_count != 64'hFFFF_FFFF) packet_count++;
      bits = window_bytes * 8;
      if (bits > BITS_CAP) bits = BITS_CAP;
      e.first_seen = first;
      e.codec_changed = cc;
      e.regular_codec_changed = rc;
      e.gap_us = gap[47:0];
      e.diff_us = diff[47:0];
      e.jitter_q4 = jit[51:0];
      e.max_gap_us = peak_gap[47:0];
      e.max_gap_packet = peak_gap_packet[31:0];
      e.max_jitter_q4 = peak_jitter[51:0];
      e.mean_diff_q4 = mean_acc[51:0];
      e.window_bits = bits[26:0];
      e.window_full = full;
      expected_stats.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, want);
    endtask

    // compare one result with the oldest expectation
    task check_stats(out_item_t g);
      out_item_t e;
      if (expected_stats.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = expected_stats.pop_front();
      if (g.window_full) n_full++;
      if (g.first_seen !== e.first_seen) report("first_seen", g.first_seen, e.first_seen);
      if (g.codec_changed !== e.codec_changed)
        report("codec_changed", g.codec_changed, e.codec_changed);
      if (g.regular_codec_changed !== e.regular_codec_changed)
        report("regular_codec_changed", g.regular_codec_changed, e.regular_codec_changed);
      if (g.gap_us !== e.gap_us) report("gap_us", g.gap_us, e.gap_us);
      if (g.diff_us !== e.diff_us) report("diff_us", g.diff_us, e.diff_us);
      if (g.jitter_q4 !== e.jitter_q4) report("jitter_q4", g.jitter_q4, e.jitter_q4);
      if (g.max_gap_us !== e.max_gap_us) report("max_gap_us", g.max_gap_us, e.max_gap_us);
      if (g.max_gap_packet !== e.max_gap_packet)
        report("max_gap_packet", g.max_gap_packet, e.max_gap_packet);
      if (g.max_jitter_q4 !== e.max_jitter_q4)
        report("max_jitter_q4", g.max_jitter_q4, e.max_jitter_q4);
      if (g.mean_diff_q4 !== e.mean_diff_q4)
        report("mean_diff_q4", g.mean_diff_q4, e.mean_diff_q4);
      if (g.window_bits !== e.window_bits)
        report("window_bits", g.window_bits, e.window_bits);
      if (g.window_full !== e.window_full)
        report("window_full", g.window_full, e.window_full);
      n_results++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vsjm_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int stall_mode = 0;

  // stream generator state
  longint unsigned cur_arr = 0;
  longint unsigned cur_ts = 0;
  logic [31:0] cur_num = 0;
  logic [31:0] cur_codec = 0;

  voice_stream_jitter_bandwidth_monitor u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("voice_stream_jitter_bandwidth_monitor test failed");
      $finish;
    end
  end

  // result side: check results and stall on a pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_stats(out_data);
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    if (!hold_done && sb.n_requests >= 400) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ((cycles / 16) % 3 == 0);
      endcase
    end
  end

  // offer one request, with bursts and gaps, and note it when taken
  task send_packet(in_item_t p);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        in_valid <= 0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data <= p;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_packet(p);
  endtask

  task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // wait for every result, then let the block settle before a register write
  task drain();
    in_valid <= 0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function in_item_t pkt(longint unsigned arr, longint unsigned ts, int unsigned len,
                         bit voice, logic [31:0] codec, logic [31:0] num);
    in_item_t p;
    p.arrival_us = arr[47:0];
    p.media_ts_ms = ts[31:0];
    p.payload_bytes = len[15:0];
    p.is_voice = voice;
    p.codec_sub = codec;
    p.packet_num = num;
    return p;
  endfunction

  // well-formed stream packet, dense packing fills the ring
  function in_item_t stream_packet(bit dense);
    int unsigned step_us;
    step_us = dense ? $urandom_range(1, 40) : $urandom_range(15000, 25000);
    cur_arr = (cur_arr + step_us + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 2000000) : 0))
              & M48;
    cur_ts = (cur_ts + (dense ? $urandom_range(0, 1) : 20)) & 64'hFFFF_FFFF;
    cur_num++;
    if ($urandom_range(0, 30) == 0) cur_codec = $urandom_range(0, 3);
    return pkt(cur_arr, cur_ts,
               ($urandom_range(0, 40) == 0) ? 65535 : $urandom_range(20, 320),
               ($urandom_range(0, 4) != 0),
               ($urandom_range(0, 50) == 0) ? $urandom : cur_codec, cur_num);
  endfunction

  function in_item_t noise_packet();
    return pkt({$urandom, $urandom}, $urandom, $urandom, 1'($urandom), $urandom, $urandom);
  endfunction

  task random_phase(int n, bit dense);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) send_packet(noise_packet());
      else send_packet(stream_packet(dense));
    end
  endtask

  initial begin
    sb.clear();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first packet, codec cases, saturations, extremes
    send_packet(pkt(1000, 5, 160, 1, 8, 0));
    send_packet(pkt(21000, 25, 160, 1, 8, 1));
    send_packet(pkt(41500, 45, 160, 1, 0, 2));
    send_packet(pkt(61000, 65, 0, 0, 32'h1234_5678, 3));
    send_packet(pkt(M48, 65, 65535, 1, 0, 4));
    send_packet(pkt(0, 65, 65535, 1, 0, 5));
    send_packet(pkt(100, 32'hFFFF_FFFF, 65535, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_packet(pkt(M48 - 5, 0, 1, 1, 32'hFFFF_FFFF, 7));
    send_packet(pkt(M48 - 9, 1, 2, 0, 0, 8));
    send_packet(pkt(40, 2, 3, 1, 3, 9));
    send_packet(pkt(0, 0, 0, 0, 0, 0));
    send_packet(pkt(20000, 20, 200, 1, 3, 10));
    cur_arr = 20000; cur_ts = 20; cur_num = 10; cur_codec = 3;
    random_phase(330, 0);
    drain();

    // one-microsecond window, no header
    write_reg(REG_WINDOW_US, 1);
    write_reg(REG_HEADER_BYTES, 0);
    random_phase(320, 0);
    random_phase(40, 1);
    drain();

    // widest window, largest header, dense stream overflows the ring
    write_reg(REG_WINDOW_US, 24'hFF_FFFF);
    write_reg(REG_HEADER_BYTES, 24'hFF_FFFF);
    random_phase(400, 1);
    random_phase(20, 0);
    drain();

    // random settings, short window so eviction walks run long
    write_reg(REG_WINDOW_US, CFG_DATA_W'($urandom_range(1000, 20000)));
    write_reg(REG_HEADER_BYTES, CFG_DATA_W'($urandom));
    random_phase(150, 1);
    random_phase(150, 0);
    drain();

    write_reg(REG_HEADER_BYTES, 24'hAA_AA55);
    write_reg(REG_WINDOW_US, 24'h55_55AA);
    random_phase(300, 1);
    drain();

    $display("covered %0d packets, %0d results, %0d forced ring drops, %0d multi-entry evictions",
             sb.n_requests, sb.n_results, sb.n_full, sb.n_evict_runs);
    if (sb.errors == 0 && sb.expected_stats.size() == 0) begin
      $display("voice_stream_jitter_bandwidth_monitor test passed");
    end else begin
      $display("voice_stream_jitter_bandwidth_monitor test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
